[src/selective_ack_scoreboard_top_macros.svh]
// ----------------------------------------------------------------------------
// Selective ack scoreboard assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_ACK_SCOREBOARD_TOP_MACROS_SVH
`define SELECTIVE_ACK_SCOREBOARD_TOP_MACROS_SVH

`ifndef SYNTH
// Assert a property on every clock edge outside reset.
`define SAS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that an expression never holds outside reset.
`define SAS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SAS_ASSERT(label, clk, rst_n, prop, msg)
`define SAS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

[src/sas_pkg.sv]
// ----------------------------------------------------------------------------
// Selective ack scoreboard package
// Word types, status codes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int ID_BITS     = 24;
    localparam int FIELD_BITS  = 16;
    localparam int POS_BITS    = 17;
    localparam int WORD_BITS   = 32;
    localparam int OFF_BITS    = 5;
    localparam int CHUNK_SPACE = 65536;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEER   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 2'd2;

    localparam logic [FIELD_BITS-1:0] WINDOW_RESET = 16'hFFFF;

    localparam logic OP_ACK  = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_NEW     = 3'd1,
        ST_DUP     = 3'd2,
        ST_FIN     = 3'd3,
        ST_SEND    = 3'd4,
        ST_DONE    = 3'd5
    } t_status;

    typedef struct packed {
        logic                  opcode;
        logic                  frame_length_ok;
        logic [FIELD_BITS-1:0] ack_source;
        logic [ID_BITS-1:0]    ack_id;
    } t_in_word;

    typedef struct packed {
        t_status               status;
        logic [FIELD_BITS-1:0] send_id;
        logic                  first_send;
        logic [FIELD_BITS-1:0] acked_total;
        logic [POS_BITS-1:0]   oldest_unacked;
        logic                  transfer_done;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    clr_we;
        logic    rd_en;
        logic    rd_sel_id;
        logic    ack_set;
        logic    fin_apply;
        logic    init_adv;
        logic    init_send;
        logic    init_retry;
        logic    scan_next;
        logic    fu_found;
        logic    fu_stop;
        logic    send_commit;
        logic    status_ld;
        t_status status;
        logic    reply;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_send;
        logic ack_ignore;
        logic ack_fin;
        logic done;
        logic bit_dup;
        logic id_is_fu;
        logic scan_found;
        logic scan_last;
        logic retry;
    } t_dp_stat;

endpackage

[src/sas_mem.sv]
// ----------------------------------------------------------------------------
// Selective ack scoreboard bitmap memory
// One write port, one registered read port, one bitmap word per entry.
// ----------------------------------------------------------------------------
module sas_mem #(
    parameter int WORDS = 2048,
    parameter int AW    = 11
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [sas_pkg::WORD_BITS-1:0]  i_wdata,
    input  logic                           i_re,
    input  logic [AW-1:0]                  i_raddr,
    output logic [sas_pkg::WORD_BITS-1:0]  o_rdata
);
    import sas_pkg::*;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/sas_ctrl.sv]
// ----------------------------------------------------------------------------
// Selective ack scoreboard controller
// Sequences bitmap clear, ack decode, pointer advance and send scans.
// ----------------------------------------------------------------------------
`include "selective_ack_scoreboard_top_macros.svh"

module sas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  sas_pkg::t_dp_stat i_stat,
    output sas_pkg::t_dp_cmd  o_cmd
);
    import sas_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ACK_CHK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_REPLY
    } t_state;

    typedef enum logic [1:0] {
        M_ADV,
        M_SEND1,
        M_SEND2
    } t_mode;

    t_state  r_state, n_state;
    t_mode   r_mode, n_mode;
    logic    r_busy;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= M_ADV;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.is_send) begin
                    priority if (i_stat.ack_ignore) begin
                        cmd.status_ld = 1'b1;
                        cmd.status    = ST_IGNORED;
                        n_state       = S_REPLY;
                    end else if (i_stat.ack_fin) begin
                        cmd.fin_apply = 1'b1;
                        cmd.status_ld = 1'b1;
                        cmd.status    = ST_FIN;
                        n_state       = S_REPLY;
                    end else begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel_id = 1'b1;
                        n_state       = S_ACK_CHK;
                    end
                end else if (i_stat.done) begin
                    cmd.status_ld = 1'b1;
                    cmd.status    = ST_DONE;
                    n_state       = S_REPLY;
                end else begin
                    cmd.init_send = 1'b1;
                    n_mode        = M_SEND1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_ACK_CHK: begin
                cmd.status_ld = 1'b1;
                if (i_stat.bit_dup) begin
                    cmd.status = ST_DUP;
                    n_state    = S_REPLY;
                end else begin
                    cmd.status  = ST_NEW;
                    cmd.ack_set = 1'b1;
                    if (i_stat.id_is_fu) begin
                        cmd.init_adv = 1'b1;
                        n_mode       = M_ADV;
                        n_state      = S_SCAN_RD;
                    end else begin
                        n_state = S_REPLY;
                    end
                end
            end
            S_SCAN_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                priority if (i_stat.scan_found) begin
                    if (r_mode == M_ADV) begin
                        cmd.fu_found = 1'b1;
                    end else begin
                        cmd.send_commit = 1'b1;
                        cmd.status_ld   = 1'b1;
                        cmd.status      = ST_SEND;
                    end
                    n_state = S_REPLY;
                end else if (i_stat.scan_last) begin
                    priority if (r_mode == M_ADV) begin
                        cmd.fu_stop = 1'b1;
                        n_state     = S_REPLY;
                    end else if (r_mode == M_SEND1 && i_stat.retry) begin
                        // wrap back to the oldest unacked chunk
                        cmd.init_retry = 1'b1;
                        n_mode         = M_SEND2;
                        n_state        = S_SCAN_RD;
                    end else begin
                        cmd.status_ld = 1'b1;
                        cmd.status    = ST_IGNORED;
                        n_state       = S_REPLY;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_REPLY: begin
                cmd.reply = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

    `SAS_ASSERT(a_clear_exit, i_clk, i_rst_n, (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE), "clear pass left to a state other than idle")
    `SAS_ASSERT(a_eval_after_read, i_clk, i_rst_n, (r_state == S_SCAN_EV) |-> ($past(r_state) == S_SCAN_RD), "scan evaluated without a bitmap read")

endmodule

[src/sas_dp.sv]
// ----------------------------------------------------------------------------
// Selective ack scoreboard datapath
// Config registers, counters, pointers, word scan logic and result register.
// ----------------------------------------------------------------------------
`include "selective_ack_scoreboard_top_macros.svh"

module sas_dp #(
    parameter int EFF_CHUNKS = 65536,
    parameter int WORDS      = 2048,
    parameter int AW         = 11
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [sas_pkg::FIELD_BITS-1:0]       i_cfg_data,
    input  sas_pkg::t_in_word                    i_word,
    input  sas_pkg::t_dp_cmd                     i_cmd,
    output sas_pkg::t_dp_stat                    o_stat,
    output sas_pkg::t_out_word                   o_res,
    output logic                                 o_res_valid,
    output logic                                 o_mem_we,
    output logic [AW-1:0]                        o_mem_waddr,
    output logic [sas_pkg::WORD_BITS-1:0]        o_mem_wdata,
    output logic                                 o_mem_re,
    output logic [AW-1:0]                        o_mem_raddr,
    input  logic [sas_pkg::WORD_BITS-1:0]        i_mem_rdata
);
    import sas_pkg::*;

    localparam logic [POS_BITS-1:0] EFF_POS   = POS_BITS'(EFF_CHUNKS);
    localparam logic [AW-1:0]       LAST_WORD = AW'(WORDS - 1);
    localparam int                  WIDX_BITS = POS_BITS - OFF_BITS;

    function automatic logic [OFF_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [OFF_BITS-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = OFF_BITS'(i);
            end
        end
        return idx;
    endfunction

    // control state
    logic [FIELD_BITS-1:0] r_total, r_peer, r_win;
    logic [FIELD_BITS-1:0] r_acked, r_highest;
    logic [POS_BITS-1:0]   r_fu, r_cursor;
    logic                  r_res_valid;
    logic [AW-1:0]         r_clr_addr;

    // payload
    t_in_word              r_in;
    logic [POS_BITS-1:0]   r_pos, r_hi;
    logic                  r_retry;
    t_status               r_status;
    logic [FIELD_BITS-1:0] r_sid;
    logic                  r_fresh;
    t_out_word             r_res;

    logic                  done;
    logic [POS_BITS-1:0]   id_lo;
    logic                  is_fin, id_over, ack_ignore;
    logic [POS_BITS-1:0]   total_p1, stop;
    logic [POS_BITS:0]     win_end;
    logic [POS_BITS-1:0]   lim_a, lim, start_sel;
    logic [OFF_BITS-1:0]   bit_off;
    logic [WORD_BITS-1:0]  lo_mask, hi_mask, cand;
    logic                  same_word, empty, found;
    logic [POS_BITS-1:0]   found_id;

    assign done  = (r_acked >= r_total);
    assign id_lo = r_in.ack_id[POS_BITS-1:0];
    assign is_fin = &r_in.ack_id;
    assign id_over = (r_in.ack_id > ID_BITS'(r_total)) || (r_in.ack_id >= ID_BITS'(EFF_POS));
    assign ack_ignore = done || !r_in.frame_length_ok || (r_in.ack_source != r_peer)
                        || (r_in.ack_id == '0) || (!is_fin && id_over);

    // pointer stops at total+1 or at the bitmap end
    assign total_p1 = POS_BITS'(r_total) + POS_BITS'(1);
    assign stop     = (total_p1 < EFF_POS) ? total_p1 : EFF_POS;

    // send window end: lowest of fu+window, total, last bitmap entry
    assign win_end   = (POS_BITS + 1)'(r_fu) + (POS_BITS + 1)'(r_win);
    assign lim_a     = (win_end > (POS_BITS + 1)'(r_total)) ? POS_BITS'(r_total)
                                                            : win_end[POS_BITS-1:0];
    assign lim       = (lim_a > EFF_POS - POS_BITS'(1)) ? EFF_POS - POS_BITS'(1) : lim_a;
    assign start_sel = (r_cursor < r_fu || r_cursor > lim) ? r_fu : r_cursor;

    assign bit_off = id_lo[OFF_BITS-1:0];

    // word scan: first clear bit in [r_pos, r_hi] within the current word
    assign same_word = (r_pos[POS_BITS-1:OFF_BITS] == r_hi[POS_BITS-1:OFF_BITS]);
    assign empty     = (r_pos > r_hi);
    assign lo_mask   = {WORD_BITS{1'b1}} << r_pos[OFF_BITS-1:0];
    assign hi_mask   = same_word
                     ? ({WORD_BITS{1'b1}} >> (OFF_BITS'(WORD_BITS - 1) - r_hi[OFF_BITS-1:0]))
                     : {WORD_BITS{1'b1}};
    assign cand      = ~i_mem_rdata & lo_mask & hi_mask;
    assign found     = !empty && (|cand);
    assign found_id  = {r_pos[POS_BITS-1:OFF_BITS], lowest_set(cand)};

    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = (r_clr_addr == LAST_WORD);
        o_stat.is_send    = (r_in.opcode == OP_SEND);
        o_stat.ack_ignore = ack_ignore;
        o_stat.ack_fin    = is_fin;
        o_stat.done       = done;
        o_stat.bit_dup    = i_mem_rdata[bit_off];
        o_stat.id_is_fu   = (id_lo == r_fu);
        o_stat.scan_found = found;
        o_stat.scan_last  = empty || same_word;
        o_stat.retry      = r_retry;
    end

    // bitmap port
    assign o_mem_we    = i_cmd.clr_we || i_cmd.ack_set;
    assign o_mem_waddr = i_cmd.clr_we ? r_clr_addr : id_lo[OFF_BITS +: AW];
    assign o_mem_wdata = i_cmd.clr_we ? '0
                                      : (i_mem_rdata | (WORD_BITS'(1) << bit_off));
    assign o_mem_re    = i_cmd.rd_en;
    assign o_mem_raddr = i_cmd.rd_sel_id ? id_lo[OFF_BITS +: AW] : r_pos[OFF_BITS +: AW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_peer      <= '0;
            r_win       <= WINDOW_RESET;
            r_acked     <= '0;
            r_highest   <= '0;
            r_fu        <= POS_BITS'(1);
            r_cursor    <= POS_BITS'(1);
            r_res_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_res_valid <= i_cmd.reply;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOTAL:  r_total <= i_cfg_data;
                    CFG_PEER:   r_peer  <= i_cfg_data;
                    CFG_WINDOW: r_win   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.ack_set) begin
                r_acked <= r_acked + FIELD_BITS'(1);
            end
            if (i_cmd.fin_apply) begin
                r_acked <= r_total;
                r_fu    <= total_p1;
            end
            if (i_cmd.fu_found) begin
                r_fu <= found_id;
            end
            if (i_cmd.fu_stop) begin
                r_fu <= stop;
            end
            if (i_cmd.send_commit) begin
                r_cursor <= found_id + POS_BITS'(1);
                if (found_id > POS_BITS'(r_highest)) begin
                    r_highest <= found_id[FIELD_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in    <= i_word;
            r_sid   <= '0;
            r_fresh <= 1'b0;
        end
        if (i_cmd.status_ld) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.init_adv) begin
            r_pos <= r_fu + POS_BITS'(1);
            r_hi  <= stop - POS_BITS'(1);
        end
        if (i_cmd.init_send) begin
            r_pos   <= start_sel;
            r_hi    <= lim;
            r_retry <= (start_sel != r_fu);
        end
        if (i_cmd.init_retry) begin
            r_pos <= r_fu;
        end
        if (i_cmd.scan_next) begin
            r_pos <= {r_pos[POS_BITS-1:OFF_BITS] + WIDX_BITS'(1), OFF_BITS'(0)};
        end
        if (i_cmd.send_commit) begin
            r_sid   <= found_id[FIELD_BITS-1:0];
            r_fresh <= (found_id > POS_BITS'(r_highest));
        end
        if (i_cmd.reply) begin
            r_res.status         <= r_status;
            r_res.send_id        <= r_sid;
            r_res.first_send     <= r_fresh;
            r_res.acked_total    <= r_acked;
            r_res.oldest_unacked <= r_fu;
            r_res.transfer_done  <= done;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    `SAS_ASSERT(a_strobe_single, i_clk, i_rst_n, r_res_valid |=> !r_res_valid, "result strobe held for more than one cycle")
    `SAS_ASSERT_NEVER(a_fu_nonzero, i_clk, i_rst_n, r_fu == '0, "oldest unacked pointer reached zero")
    `SAS_ASSERT(a_count_step, i_clk, i_rst_n, i_cmd.ack_set |=> (r_acked == $past(r_acked) + FIELD_BITS'(1)), "acked count did not step on a new ack")

endmodule

[src/selective_ack_scoreboard_top.sv]
// ----------------------------------------------------------------------------
// Selective ack scoreboard
// Sender-side selective-repeat scoreboard: one ack bit per chunk in a bitmap
// memory of 32-bit words, ack accounting, oldest-unacked tracking and a
// windowed search for the next chunk to send.
//
// Flow: an accepted item passes decode and reply for ignored, FIN and
//   completion items, decode, ack check and reply for duplicate or new acks,
//   plus read and evaluate states per 32-chunk word walked by an advance or send scan.
// Throughput: one item at a time; start is taken again in the strobe cycle.
// Reset: synchronous; a clearing pass then zeros the bitmap one word a cycle
//   with busy held high.
// Results cannot be stalled: each word is marked on o_res_valid for one strobe cycle.
// ----------------------------------------------------------------------------
module selective_ack_scoreboard_top #(
    parameter int MAX_CHUNKS = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item port
    input  logic                             start,
    output logic                             busy,
    input  sas_pkg::t_in_word                i_cmd,
    // result port
    output sas_pkg::t_out_word               o_res,
    output logic                             o_res_valid,
    // register write port
    input  logic                             i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [sas_pkg::FIELD_BITS-1:0]   i_cfg_data
);
    import sas_pkg::*;

    // ids never exceed the 16-bit total, so the bitmap caps at that space
    localparam int EFF_CHUNKS = (MAX_CHUNKS < CHUNK_SPACE) ? MAX_CHUNKS : CHUNK_SPACE;
    localparam int WORDS      = (EFF_CHUNKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_dp_cmd              cmd;
    t_dp_stat             stat;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

    // sequencer: clear pass, decode, read-modify-write, word scans
    sas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // registers, pointer/window arithmetic and the per-word bit search
    sas_dp #(
        .EFF_CHUNKS (EFF_CHUNKS),
        .WORDS      (WORDS),
        .AW         (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_word      (i_cmd),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // ack bitmap, one 32-chunk word per entry
    sas_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
